// File: rtl/float_add_subtract_unit_macros.svh
// assertion macros for the float add/subtract unit
`ifndef FLOAT_ADD_SUBTRACT_UNIT_MACROS_SVH
`define FLOAT_ADD_SUBTRACT_UNIT_MACROS_SVH

// property that holds outside reset
`define FAS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked during reset as well
`define FAS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: rtl/fas_pkg.sv
// shared constants and types for the float add/subtract unit
package fas_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned GuardBits = 6;
   // aligned magnitude: hidden one, fraction, guard bits, one carry bit
   localparam int unsigned MagWidth = FracWidth + 1 + GuardBits + 1;
   localparam logic [ExpWidth-1:0] ExpAllOnes = '1;
   localparam logic [ExpWidth-1:0] ExpBias = 8'd127;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUB = 1'b1
   } op_type;

   typedef logic [WordWidth-1:0] word_type;
endpackage

// File: rtl/float_add_subtract_unit.sv
// float add/subtract unit: single-pass datapath between request and result registers
// an accepted request passes the request register and then the result register before its rsp_valid strobe
// throughput: one request per cycle; busy is tied low, the sum logic is one registered pass
// the long path is alignment shift, 31-bit add, leading-one shift and exponent adjust
// reset (synchronous, active high) clears the valid flags only; operand registers are not reset
// the receiver cannot stall, so each result shows for exactly one cycle
`include "float_add_subtract_unit_macros.svh"

module float_add_subtract_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  fas_pkg::word_type     req_a,
   input  fas_pkg::word_type     req_b,
   output logic                  rsp_valid,
   output fas_pkg::word_type     rsp_result
);

   localparam int unsigned MW = fas_pkg::MagWidth;

   // request register
   logic              req_valid_ff;
   logic              req_op_ff;
   fas_pkg::word_type a_ff, b_ff;

   // result register
   logic              rsp_valid_ff;
   fas_pkg::word_type result_ff, result_in;

   // decoded operands
   logic [7:0]        ea, eb;
   logic [9:0]        diff_ab, diff_ba;
   logic [MW-1:0]     mag_a, mag_b, big, lesser, small_sh, sum;
   logic              sa, sb, sign;
   logic [4:0]        shamt;
   logic [9:0]        s_exp;          // signed exponent, unbiased
   logic [MW-1:0]     norm;
   logic [4:0]        lz;
   logic              found;
   logic [25:0]       wide;

   always_comb begin
      fas_pkg::word_type bb;
      bb = b_ff;
      if (fas_pkg::op_type'(req_op_ff) == fas_pkg::OP_SUB) bb[31] = ~bb[31];

      ea = a_ff[30:23];
      eb = bb[30:23];
      sa = a_ff[31];
      sb = bb[31];
      diff_ab = {2'b00, ea} - {2'b00, eb};
      diff_ba = {2'b00, eb} - {2'b00, ea};
      mag_a = {1'b0, 1'b1, a_ff[22:0], 6'b0};
      mag_b = {1'b0, 1'b1, bb[22:0], 6'b0};

      // order so that big has the larger exponent, or the larger magnitude on a tie
      if (ea > eb || (ea == eb && mag_a >= mag_b)) begin
         big = mag_a; lesser = mag_b; sign = sa; shamt = diff_ab[4:0];
         s_exp = {2'b00, ea} - 10'd127;
      end else begin
         big = mag_b; lesser = mag_a; sign = sb; shamt = diff_ba[4:0];
         s_exp = {2'b00, eb} - 10'd127;
      end
      // equal exponents with like signs: model keeps a's sign, same thing
      small_sh = lesser >> shamt;
      sum = (sa == sb) ? big + small_sh : big - small_sh;
      s_exp = s_exp - 10'(fas_pkg::GuardBits);

      wide = '0;
      norm = '0;
      lz = '0;
      found = 1'b0;
      if (sum > MW'(32'hFFFFFF)) begin
         // sum fits in 31 bits; truncate to 25 bits, round, fit 24
         if (sum > MW'(32'h1FFFFFF)) begin
            // leading one at bit 25..30
            lz = '0;
            for (int i = 25; i <= 30; i++) if (sum[i]) lz = 5'(i - 24);
            wide = 26'(sum >> lz);
            s_exp = s_exp + 10'(lz);
         end else wide = {1'b0, sum[24:0]};
         if (wide[0]) wide = wide + 26'd1;
         // rounding an all-ones value carries out to bit 25
         if (wide[25]) begin
            wide = wide >> 2;
            s_exp = s_exp + 10'd2;
         end else if (wide[24]) begin
            wide = wide >> 1;
            s_exp = s_exp + 10'd1;
         end
         norm = MW'(wide);
      end else begin
         // shift left until bit 23 set
         for (int i = 23; i >= 0; i--) begin
            if (!found && sum[i]) begin
               found = 1'b1;
               lz = 5'(23 - i);
            end
         end
         norm = sum << lz;
         s_exp = s_exp - 10'(lz);
      end

      if ($signed(s_exp) > 10'sd127) result_in = {sign, 8'hFF, 23'd0};
      else if ($signed(s_exp) < -10'sd127) result_in = {sign, 31'd0};
      else result_in = {sign, 8'(s_exp + 10'd127), norm[22:0]};
      if (sum == '0) result_in = '0;

      // special cases in the model's order of precedence
      if (diff_ba[9] == 1'b0 && diff_ba > 10'd23) result_in = bb;
      if (diff_ab[9] == 1'b0 && diff_ab > 10'd23) result_in = a_ff;
      if (eb == fas_pkg::ExpAllOnes) result_in = bb;
      if (ea == fas_pkg::ExpAllOnes) result_in = a_ff;
      if (bb[30:0] == 31'd0) result_in = a_ff;
      if (a_ff[30:0] == 31'd0) result_in = bb;
   end

   // request and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
         rsp_valid_ff <= req_valid_ff;
      end
      a_ff      <= req_a;
      b_ff      <= req_b;
      req_op_ff <= req_op;
      result_ff <= result_in;
   end

   assign busy       = 1'b0;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   `FAS_ASSERT(a_resp_follows, start |=> ##1 rsp_valid, "accepted request gave no result")
   `FAS_ASSERT(a_no_spurious, !start |=> ##1 !rsp_valid, "result without request")
   `FAS_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "result right after reset")
endmodule

// File: verif/testbench.sv
// self-checking testbench for the float add/subtract unit
`timescale 1ns / 100ps

module testbench;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_op = 1'b0;
   fas_pkg::word_type req_a = '0;
   fas_pkg::word_type req_b = '0;
   logic              rsp_valid;
   fas_pkg::word_type rsp_result;

   float_add_subtract_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_a(req_a), .req_b(req_b),
      .rsp_valid(rsp_valid), .rsp_result(rsp_result)
   );

   always #6 clock = ~clock;

   // sums still to come out, oldest first
   fas_pkg::word_type pending_sums[$];
   int                error_count = 0;

   // bit-exact sum of two words, b already sign-flipped for subtract
   function automatic fas_pkg::word_type fp_sum(fas_pkg::word_type a, fas_pkg::word_type b);
      logic        sa, sb, sgn;
      logic [31:0] ma, mb, sum;
      int          ea, eb, s;
      logic [7:0]  ef;
      if (a[30:0] == '0) return b;
      if (b[30:0] == '0) return a;
      if (a[30:23] == fas_pkg::ExpAllOnes) return a;
      if (b[30:23] == fas_pkg::ExpAllOnes) return b;
      ea = int'(a[30:23]) - 127;
      eb = int'(b[30:23]) - 127;
      if (ea - eb > 23) return a;
      if (eb - ea > 23) return b;
      sa = a[31];
      sb = b[31];
      ma = {8'd0, 1'b1, a[22:0]} << fas_pkg::GuardBits;
      mb = {8'd0, 1'b1, b[22:0]} << fas_pkg::GuardBits;
      if (ea == eb) begin
         s = ea;
         if (sa == sb) begin
            sum = ma + mb; sgn = sa;
         end else if (ma >= mb) begin
            sum = ma - mb; sgn = sa;
         end else begin
            sum = mb - ma; sgn = sb;
         end
      end else if (ea > eb) begin
         s = ea; sgn = sa;
         mb = mb >> (ea - eb);
         sum = (sa == sb) ? ma + mb : ma - mb;
      end else begin
         s = eb; sgn = sb;
         ma = ma >> (eb - ea);
         sum = (sa == sb) ? mb + ma : mb - ma;
      end
      if (sum == 0) return '0;
      s = s - int'(fas_pkg::GuardBits);
      if (sum > 32'h00FF_FFFF) begin
         while (sum > 32'h01FF_FFFF) begin
            sum = sum >> 1; s++;
         end
         if (sum[0]) sum = sum + 32'd1;
         while (sum > 32'h00FF_FFFF) begin
            sum = sum >> 1; s++;
         end
      end else begin
         while (sum < 32'h0080_0000) begin
            sum = sum << 1; s--;
         end
      end
      sum = sum & 32'h007F_FFFF;
      if (s > 127) begin
         sum = 0; ef = fas_pkg::ExpAllOnes;
      end else if (s < -127) begin
         sum = 0; ef = '0;
      end else begin
         ef = 8'(s + 127);
      end
      return {sgn, ef, sum[22:0]};
   endfunction

   // directed requests; expected sum typed in where obvious, else predicted
   typedef struct {
      fas_pkg::op_type   op;
      fas_pkg::word_type a;
      fas_pkg::word_type b;
      logic              typed;
      fas_pkg::word_type sum;
   } directed_row_type;

   directed_row_type directed_rows[] = '{
      '{fas_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{fas_pkg::OP_ADD, 32'h8000_0000, 32'h3F80_0000, 1'b1, 32'h3F80_0000},  // zero a
      '{fas_pkg::OP_SUB, 32'h0000_0000, 32'h3F80_0000, 1'b1, 32'hBF80_0000},  // flip b
      '{fas_pkg::OP_ADD, 32'h4040_0000, 32'h8000_0000, 1'b1, 32'h4040_0000},  // zero b
      '{fas_pkg::OP_ADD, 32'h7F80_0000, 32'h3F80_0000, 1'b1, 32'h7F80_0000},  // inf a
      '{fas_pkg::OP_SUB, 32'h3F80_0000, 32'h7FC0_0001, 1'b1, 32'hFFC0_0001},  // nan b
      '{fas_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{fas_pkg::OP_ADD, 32'h4B80_0000, 32'h3F80_0000, 1'b1, 32'h4B80_0000},  // far apart
      '{fas_pkg::OP_ADD, 32'h3F80_0000, 32'h4B80_0000, 1'b1, 32'h4B80_0000},
      '{fas_pkg::OP_SUB, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000},  // cancel
      '{fas_pkg::OP_ADD, 32'hBF80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000},
      '{fas_pkg::OP_ADD, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000},
      '{fas_pkg::OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},  // overflow
      '{fas_pkg::OP_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'hFF80_0000},
      '{fas_pkg::OP_SUB, 32'h0000_0003, 32'h0000_0002, 1'b0, 32'h0},  // underflow
      '{fas_pkg::OP_ADD, 32'h0000_0001, 32'h0000_0001, 1'b0, 32'h0},  // smallest exponent
      '{fas_pkg::OP_ADD, 32'h4B7F_FFFF, 32'h3F80_0000, 1'b0, 32'h0},  // rounding carry
      '{fas_pkg::OP_ADD, 32'h3FFF_FFFF, 32'h3400_0001, 1'b0, 32'h0},
      '{fas_pkg::OP_SUB, 32'h4000_0000, 32'h3FFF_FFFF, 1'b0, 32'h0},
      '{fas_pkg::OP_ADD, 32'h007F_FFFF, 32'h807F_FFFE, 1'b0, 32'h0},
      '{fas_pkg::OP_SUB, 32'hC2F6_0000, 32'h4148_0000, 1'b0, 32'h0}
   };

   // queue one request and hold it until accepted
   task automatic send_request(fas_pkg::op_type op, fas_pkg::word_type a,
                               fas_pkg::word_type b, logic typed,
                               fas_pkg::word_type sum, bit allow_gap);
      while (allow_gap && $urandom_range(99) < 16) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start  <= 1'b1;
      req_op <= op;
      req_a  <= a;
      req_b  <= b;
      pending_sums.push_back(typed ? sum :
                             fp_sum(a, op == fas_pkg::OP_SUB ? {~b[31], b[30:0]} : b));
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // random operand with weighted exponent shapes
   function automatic fas_pkg::word_type pick_word(fas_pkg::word_type near);
      fas_pkg::word_type w;
      w = $urandom;
      case ($urandom_range(9))
         0: w[30:23] = near[30:23] + 8'($urandom_range(2)) - 8'd1;
         1: w[30:23] = $urandom_range(1) ? fas_pkg::ExpAllOnes : 8'd0;
         2: w[30:0] = $urandom_range(1) ? '0 : {8'd0, 23'($urandom)};
         3: w[30:23] = 8'($urandom_range(255, 240));
         4: w = {~near[31], near[30:0]} ^ fas_pkg::word_type'($urandom_range(3));
         default: w[30:23] = near[30:23] + 8'($urandom_range(30)) - 8'd15;
      endcase
      return w;
   endfunction

   // check each strobed result against the oldest pending sum
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_result);
            error_count++;
         end else begin
            fas_pkg::word_type want;
            want = pending_sums.pop_front();
            if (rsp_result !== want) begin
               $display("%0t: result mismatch, expected %h, actual %h",
                        $time, want, rsp_result);
               error_count++;
            end
         end
      end
   end

   initial begin
      fas_pkg::word_type a;
      int                waited;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].typed, directed_rows[i].sum, 1'b1);
      // random requests; a run in the middle goes without gaps
      for (int n = 0; n < 550; n++) begin
         a = pick_word($urandom);
         send_request(fas_pkg::op_type'($urandom_range(1)), a, pick_word(a), 1'b0, '0,
                      !(n >= 200 && n < 300));
      end
      start <= 1'b0;
      waited = 0;
      while (pending_sums.size() != 0 && waited < 1000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (error_count == 0 && pending_sums.size() == 0)
         $display("float_add_subtract_unit verification clean");
      else
         $display("float_add_subtract_unit verification failed");
      $finish;
   end

   // hard stop if the handshake hangs
   initial begin
      #2_000_000;
      $display("float_add_subtract_unit verification failed");
      $finish;
   end
endmodule
